// ===== rtl/playfair_digraph_encrypt_core_macros.svh =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt core assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PFDE_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfde check failed");

`define PFDE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfde check failed");

`else

`define PFDE_ASSERT_SAME(lbl, ante, cons)
`define PFDE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt package
// Shared types, constants and square geometry helpers.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int LETTERS        = 26;
  localparam int CELLS          = 25;
  localparam int LETTER_I       = 8;
  localparam int LETTER_J       = 9;
  localparam int DEFAULT_FILLER = 23;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;
  typedef logic [1:0] op_t;

  localparam op_t OP_KEY  = 2'd0;
  localparam op_t OP_TEXT = 2'd1;
  localparam op_t OP_END  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FILL,
    S_POS,
    S_SQ
  } state_t;

  function automatic letter_t fold_letter(input letter_t v);
    return (v == letter_t'(LETTER_J)) ? letter_t'(LETTER_I) : v;
  endfunction

  function automatic coord_t cell_row(input cell_t a);
    coord_t r;
    if (a >= cell_t'(20))      r = 3'd4;
    else if (a >= cell_t'(15)) r = 3'd3;
    else if (a >= cell_t'(10)) r = 3'd2;
    else if (a >= cell_t'(5))  r = 3'd1;
    else                       r = 3'd0;
    return r;
  endfunction

  function automatic coord_t cell_col(input cell_t a);
    coord_t r;
    cell_t  base;
    r    = cell_row(a);
    base = cell_t'({r, 2'b00}) + cell_t'(r);
    return coord_t'(a - base);
  endfunction

  function automatic cell_t cell_at(input coord_t r, input coord_t c);
    return cell_t'({r, 2'b00}) + cell_t'(r) + cell_t'(c);
  endfunction

  function automatic coord_t wrap_inc(input coord_t c);
    return (c == 3'd4) ? 3'd0 : coord_t'(c + 3'd1);
  endfunction

endpackage

// ===== rtl/pfde_in_if.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt input channel
// Valid/ready channel carrying one tagged letter word.
// ----------------------------------------------------------------------------
interface pfde_in_if;
  logic              valid;
  logic              ready;
  pfde_pkg::op_t     op;
  pfde_pkg::letter_t letter;

  modport source (output valid, output op, output letter, input ready);
  modport sink   (input valid, input op, input letter, output ready);
endinterface

// ===== rtl/pfde_out_if.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt result channel
// Valid/ready channel carrying one enciphered pair word.
// ----------------------------------------------------------------------------
interface pfde_out_if;
  logic              valid;
  logic              ready;
  pfde_pkg::letter_t cipher_first;
  pfde_pkg::letter_t cipher_second;

  modport source (output valid, output cipher_first, output cipher_second, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second, output ready);
endinterface

// ===== rtl/playfair_digraph_encrypt_core.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt core
// Builds a 5x5 key square from key letters and enciphers text letter pairs.
// ----------------------------------------------------------------------------
// One word is taken at a time. A key letter, or a text letter that only opens a
// pair, is handled in S_EXEC alone; a word that yields a pair goes on to S_POS
// and S_SQ: the letter positions and then the square cells are looked up in turn
// through the read ports of the two RAMs. The first text letter also walks the
// alphabet once in S_FILL to finish the square. A finished pair waits in the output
// register while the next word is taken; a second pair stalls until it drains.
`include "playfair_digraph_encrypt_core_macros.svh"

module playfair_digraph_encrypt_core (
  input  logic              clk,
  input  logic              rst_n,
  pfde_in_if.sink           in_chan,
  pfde_out_if.source        out_chan,
  input  logic              cfg_wr_en,
  input  pfde_pkg::letter_t cfg_wr_data
);

  import pfde_pkg::*;

  state_t  state_r, state_nxt;
  op_t     op_r;
  letter_t letter_r;
  letter_t filler_r;
  logic [LETTERS-1:0] used_r, used_nxt;
  cell_t   fill_r, fill_nxt;
  logic    complete_r, complete_nxt;
  letter_t held_r, held_nxt;
  logic    holding_r, holding_nxt;
  letter_t walk_r, walk_nxt;
  logic    out_valid_r, out_valid_nxt;
  letter_t out_first_r, out_second_r;
  logic    out_load;

  letter_t v_fold, filler_eff, place_v;
  logic    v_ok, place_try, place_ok;

  logic    pos_re, sq_re;
  letter_t pos_ra_a, pos_ra_b;
  cell_t   pos_rd_a, pos_rd_b;
  cell_t   sq_ra_a, sq_ra_b;
  letter_t sq_rd_a, sq_rd_b;
  coord_t  r1, c1, r2, c2;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.cipher_first  = out_first_r;
  assign out_chan.cipher_second = out_second_r;

  assign v_ok       = (letter_r < letter_t'(LETTERS));
  assign v_fold     = fold_letter(letter_r);
  assign filler_eff = (filler_r >= letter_t'(LETTERS)) ? letter_t'(DEFAULT_FILLER)
                                                       : fold_letter(filler_r);
  assign place_ok   = place_try && (place_v < letter_t'(LETTERS)) &&
                      !used_r[place_v] && (fill_r < cell_t'(CELLS));

  assign r1 = cell_row(pos_rd_a);
  assign c1 = cell_col(pos_rd_a);
  assign r2 = cell_row(pos_rd_b);
  assign c2 = cell_col(pos_rd_b);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    fill_nxt      = fill_r;
    complete_nxt  = complete_r;
    held_nxt      = held_r;
    holding_nxt   = holding_r;
    walk_nxt      = walk_r;
    place_v       = v_fold;
    place_try     = 1'b0;
    pos_re        = 1'b0;
    pos_ra_a      = held_r;
    pos_ra_b      = v_fold;
    sq_re         = 1'b0;
    sq_ra_a       = '0;
    sq_ra_b       = '0;
    out_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (op_r)
          OP_KEY: begin
            place_try = v_ok && !complete_r;
          end
          OP_TEXT: begin
            if (v_ok) begin
              if (!complete_r) begin
                walk_nxt  = '0;
                state_nxt = S_FILL;
              end else if (!holding_r) begin
                held_nxt    = v_fold;
                holding_nxt = 1'b1;
              end else begin
                pos_re    = 1'b1;
                state_nxt = S_POS;
                if (held_r == v_fold) begin
                  pos_ra_b = filler_eff;
                end else begin
                  holding_nxt = 1'b0;
                end
              end
            end
          end
          OP_END: begin
            if (holding_r) begin
              pos_re      = 1'b1;
              pos_ra_b    = filler_eff;
              holding_nxt = 1'b0;
              state_nxt   = S_POS;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FILL: begin
        place_v   = walk_r;
        place_try = (walk_r != letter_t'(LETTER_J));
        walk_nxt  = walk_r + letter_t'(1);
        if (walk_r == letter_t'(LETTERS - 1)) begin
          complete_nxt = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_POS: begin
        sq_re = 1'b1;
        if (r1 == r2) begin
          sq_ra_a = cell_at(r1, wrap_inc(c1));
          sq_ra_b = cell_at(r2, wrap_inc(c2));
        end else if (c1 == c2) begin
          sq_ra_a = cell_at(wrap_inc(r1), c1);
          sq_ra_b = cell_at(wrap_inc(r2), c2);
        end else begin
          sq_ra_a = cell_at(r1, c2);
          sq_ra_b = cell_at(r2, c1);
        end
        state_nxt = S_SQ;
      end
      S_SQ: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (place_ok) begin
      used_nxt = used_r | (LETTERS'(1) << place_v);
      fill_nxt = fill_r + cell_t'(1);
    end

    out_valid_nxt = out_load | (out_valid_r & ~out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      filler_r    <= letter_t'(DEFAULT_FILLER);
      used_r      <= '0;
      fill_r      <= '0;
      complete_r  <= 1'b0;
      held_r      <= '0;
      holding_r   <= 1'b0;
      walk_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      complete_r  <= complete_nxt;
      held_r      <= held_nxt;
      holding_r   <= holding_nxt;
      walk_r      <= walk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        filler_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      op_r     <= in_chan.op;
      letter_r <= in_chan.letter;
    end
    if (out_load) begin
      out_first_r  <= sq_rd_a;
      out_second_r <= sq_rd_b;
    end
  end

  // cell index of each letter
  pfde_ram #(
    .WIDTH (5),
    .DEPTH (LETTERS)
  ) u_pos_ram (
    .clk     (clk),
    .we      (place_ok),
    .waddr   (place_v),
    .wdata   (fill_r),
    .re      (pos_re),
    .raddr_a (pos_ra_a),
    .raddr_b (pos_ra_b),
    .rdata_a (pos_rd_a),
    .rdata_b (pos_rd_b)
  );

  // letter held in each cell
  pfde_ram #(
    .WIDTH (5),
    .DEPTH (CELLS)
  ) u_square_ram (
    .clk     (clk),
    .we      (place_ok),
    .waddr   (fill_r),
    .wdata   (place_v),
    .re      (sq_re),
    .raddr_a (sq_ra_a),
    .raddr_b (sq_ra_b),
    .rdata_a (sq_rd_a),
    .rdata_b (sq_rd_b)
  );

  `PFDE_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= cell_t'(CELLS))
  `PFDE_ASSERT_SAME(a_square_full, complete_r, fill_r == cell_t'(CELLS))
  `PFDE_ASSERT_NEXT(a_complete_sticky, complete_r, complete_r)
  `PFDE_ASSERT_NEXT(a_lookup_order, state_r == S_POS, state_r == S_SQ)

endmodule

// ===== rtl/pfde_ram.sv =====
// ----------------------------------------------------------------------------
// Playfair digraph encrypt RAM
// Generic one-write, two-read memory with registered read data.
// ----------------------------------------------------------------------------
module pfde_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 25
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
